@@ src/qbs_pkg.sv @@
package qbs_pkg;

   // Path geometry and coordinate format
   localparam int SEGMENTS    = 3;
   localparam int COORD_WIDTH = 32;

   // Control points after end reflection need two extra bits
   localparam int QW   = COORD_WIDTH + 2;
   localparam int KW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int DEN  = 2 * SEGMENTS * SEGMENTS;
   localparam int HALF = SEGMENTS * SEGMENTS;
   localparam int CW   = $clog2(DEN + 1);

   // Rounded numerator magnitude, with slack for the rounding offset
   localparam int MW   = COORD_WIDTH + 6 + $clog2(HALF);
   localparam int NW   = MW + 1;
   localparam int LO_W = (MW + 1) / 2;
   localparam int HI_W = MW - LO_W;

   // Reciprocal of the denominator, truncated; one correction step follows
   localparam logic [MW-1:0]   RECIP    = MW'((64'd1 << MW) / 64'(DEN));
   localparam logic [HI_W-1:0] RECIP_HI = RECIP[MW-1:LO_W];
   localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];

   // Saturation bounds as magnitudes
   localparam logic [MW-1:0] SAT_POS = MW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic [MW-1:0] SAT_NEG = MW'(64'd1 << (COORD_WIDTH - 1));

   typedef struct packed {
      logic signed [QW-1:0] q0;
      logic signed [QW-1:0] q1;
      logic signed [QW-1:0] q2;
   } triple_type;

   // One result to evaluate: control triples per axis, sample index, end flag
   typedef struct packed {
      triple_type    tx;
      triple_type    ty;
      logic [KW-1:0] k;
      logic          last;
   } step_type;

   // Load enables of the evaluation stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } pipe_en_type;

   // Weight of the slope term: 2*S*k
   function automatic logic [CW-1:0] coef_lin(input logic [KW-1:0] k);
      coef_lin = CW'(2 * SEGMENTS) * CW'(k);
   endfunction

   // Weight of the curvature term: k*k
   function automatic logic [CW-1:0] coef_crv(input logic [KW-1:0] k);
      coef_crv = CW'(k) * CW'(k);
   endfunction

endpackage

@@ src/qbs_req_if.sv @@
interface qbs_req_if;
   import qbs_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          final_point;

   modport source (output valid, output point_x, output point_y, output final_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input final_point,
                   output ready);
endinterface

@@ src/qbs_rsp_if.sv @@
interface qbs_rsp_if;
   import qbs_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] smooth_x;
   logic signed [COORD_WIDTH-1:0] smooth_y;
   logic                          path_end;

   modport source (output valid, output smooth_x, output smooth_y, output path_end,
                   input ready);
   modport sink   (input valid, input smooth_x, input smooth_y, input path_end,
                   output ready);
endinterface

@@ src/qbs_seq.sv @@
module qbs_seq (
   input  logic               clock,
   input  logic               reset,
   qbs_req_if.sink            req,
   output qbs_pkg::step_type  step,
   output logic               step_valid,
   input  logic               step_ready
);
   import qbs_pkg::*;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;

   // Pending work of the current item, done lowest bit first
   localparam int JOB_W = 4;
   localparam logic [JOB_W-1:0] JOB_NONE  = 4'b0000;
   localparam logic [JOB_W-1:0] JOB_SEG1  = 4'b0001;
   localparam logic [JOB_W-1:0] JOB_SEG2  = 4'b0010;
   localparam logic [JOB_W-1:0] JOB_NEWER = 4'b0100;
   localparam logic [JOB_W-1:0] JOB_CUR   = 4'b1000;

   localparam logic [KW-1:0] K_LAST = KW'(SEGMENTS - 1);

   // Path history
   logic signed [COORD_WIDTH-1:0] older_x_ff, older_x_in, older_y_ff, older_y_in;
   logic signed [COORD_WIDTH-1:0] newer_x_ff, newer_x_in, newer_y_ff, newer_y_in;
   logic [1:0]                    seen_ff, seen_in;

   // Job: q0 q1 q2 form the first segment, q1 q2 q3 the closing one
   logic signed [QW-1:0] qx_ff [4];
   logic signed [QW-1:0] qx_in [4];
   logic signed [QW-1:0] qy_ff [4];
   logic signed [QW-1:0] qy_in [4];
   logic [JOB_W-1:0]     pend_ff, pend_in;
   logic [KW-1:0]        k_ff, k_in;

   logic                 accept, take, step_done, in_seg;
   logic [JOB_W-1:0]     cur_bit, rest;
   logic signed [QW-1:0] xe, ye, nxe, nye;

   // Step issue
   always_comb begin
      cur_bit    = pend_ff & (~pend_ff + 1'b1);
      rest       = pend_ff & ~cur_bit;
      in_seg     = |(cur_bit & (JOB_SEG1 | JOB_SEG2));
      step_valid = (pend_ff != JOB_NONE);
      take       = step_valid && step_ready;
      step_done  = take && (!in_seg || (k_ff == K_LAST));
      req.ready  = !step_valid || (step_done && (rest == JOB_NONE));
      accept     = req.valid && req.ready;

      step.k    = k_ff;
      step.last = 1'b0;
      if ((cur_bit & JOB_SEG2) != JOB_NONE) begin
         step.tx = '{q0: qx_ff[1], q1: qx_ff[2], q2: qx_ff[3]};
         step.ty = '{q0: qy_ff[1], q1: qy_ff[2], q2: qy_ff[3]};
      end else if ((cur_bit & JOB_NEWER) != JOB_NONE) begin
         step.tx = '{q0: qx_ff[1], q1: qx_ff[1], q2: qx_ff[1]};
         step.ty = '{q0: qy_ff[1], q1: qy_ff[1], q2: qy_ff[1]};
         step.k  = '0;
      end else if ((cur_bit & JOB_CUR) != JOB_NONE) begin
         step.tx   = '{q0: qx_ff[2], q1: qx_ff[2], q2: qx_ff[2]};
         step.ty   = '{q0: qy_ff[2], q1: qy_ff[2], q2: qy_ff[2]};
         step.k    = '0;
         step.last = 1'b1;
      end else begin
         step.tx = '{q0: qx_ff[0], q1: qx_ff[1], q2: qx_ff[2]};
         step.ty = '{q0: qy_ff[0], q1: qy_ff[1], q2: qy_ff[2]};
      end
   end

   // Next job and path history
   always_comb begin
      xe  = QW'(req.point_x);
      ye  = QW'(req.point_y);
      nxe = QW'(newer_x_ff);
      nye = QW'(newer_y_ff);

      older_x_in = older_x_ff;
      older_y_in = older_y_ff;
      newer_x_in = newer_x_ff;
      newer_y_in = newer_y_ff;
      seen_in    = seen_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      pend_in    = pend_ff;
      k_in       = k_ff;

      if (step_done) begin
         pend_in = rest;
         k_in    = '0;
      end else if (take) begin
         k_in = k_ff + 1'b1;
      end

      if (accept) begin
         // Reflected front point for the second point, else the point two back
         qx_in[0] = (seen_ff == SEEN_ONE) ? (nxe + nxe - xe) : QW'(older_x_ff);
         qy_in[0] = (seen_ff == SEEN_ONE) ? (nye + nye - ye) : QW'(older_y_ff);
         qx_in[1] = nxe;
         qy_in[1] = nye;
         qx_in[2] = xe;
         qy_in[2] = ye;
         qx_in[3] = xe + xe - nxe;
         qy_in[3] = ye + ye - nye;
         k_in     = '0;
         case (seen_ff)
            SEEN_NONE: begin
               pend_in = req.final_point ? JOB_CUR : JOB_NONE;
            end
            SEEN_ONE: begin
               pend_in = req.final_point ? (JOB_NEWER | JOB_CUR) : JOB_SEG1;
            end
            default: begin
               pend_in = req.final_point ? (JOB_SEG1 | JOB_SEG2 | JOB_CUR) : JOB_SEG1;
            end
         endcase
         if (req.final_point) begin
            seen_in = SEEN_NONE;
         end else begin
            older_x_in = newer_x_ff;
            older_y_in = newer_y_ff;
            newer_x_in = req.point_x;
            newer_y_in = req.point_y;
            seen_in    = (seen_ff == SEEN_NONE) ? SEEN_ONE : SEEN_TWO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= SEEN_NONE;
         pend_ff <= JOB_NONE;
         k_ff    <= '0;
      end else begin
         seen_ff <= seen_in;
         pend_ff <= pend_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      older_x_ff <= older_x_in;
      older_y_ff <= older_y_in;
      newer_x_ff <= newer_x_in;
      newer_y_ff <= newer_y_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
   end

`ifndef NO_ASSERTIONS
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req.final_point |=> seen_ff == SEEN_NONE)
      else $error("path history not cleared after final point");
   a_first_no_job: assert property (@(posedge clock) disable iff (reset)
      accept && !req.final_point && seen_ff == SEEN_NONE |=> pend_ff == JOB_NONE)
      else $error("first point started a job");
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= K_LAST)
      else $error("sample index out of range");
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd3)
      else $error("point count past saturation");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      step_valid && !step_ready |=> step_valid && $stable(k_ff) && $stable(pend_ff))
      else $error("job advanced while stalled");
`endif

endmodule

@@ src/qbs_lane.sv @@
module qbs_lane (
   input  logic                                   clock,
   input  qbs_pkg::pipe_en_type                   en,
   input  qbs_pkg::triple_type                    trip,
   input  logic [qbs_pkg::KW-1:0]                 k,
   output logic signed [qbs_pkg::COORD_WIDTH-1:0] value
);
   import qbs_pkg::*;

   localparam logic signed [NW-1:0] SQ_C = NW'(HALF);

   // Stage 1: numerator, then magnitude plus rounding offset
   logic signed [NW-1:0] e0, e1, e2, sum_a, dif_b, crv_d, c_lin, c_crv, num, absv;
   logic [MW-1:0]        mag1_in, mag1_ff;
   logic                 neg1_ff;

   always_comb begin
      e0      = NW'($signed(trip.q0));
      e1      = NW'($signed(trip.q1));
      e2      = NW'($signed(trip.q2));
      sum_a   = e0 + e1;
      dif_b   = e1 - e0;
      crv_d   = e0 - e1 - e1 + e2;
      c_lin   = NW'(coef_lin(k));
      c_crv   = NW'(coef_crv(k));
      num     = SQ_C * sum_a + c_lin * dif_b + c_crv * crv_d;
      absv    = num[NW-1] ? -num : num;
      mag1_in = MW'(absv) + MW'(HALF);
   end

   // Stage 2: partial products of magnitude times reciprocal
   logic [2*HI_W-1:0] hh2_in, hh2_ff;
   logic [MW-1:0]     hl2_in, hl2_ff, lh2_in, lh2_ff, mag2_ff;
   logic [2*LO_W-1:0] ll2_in, ll2_ff;
   logic              neg2_ff;

   always_comb begin
      hh2_in = (2*HI_W)'(mag1_ff[MW-1:LO_W]) * (2*HI_W)'(RECIP_HI);
      hl2_in = MW'(mag1_ff[MW-1:LO_W]) * MW'(RECIP_LO);
      lh2_in = MW'(mag1_ff[LO_W-1:0]) * MW'(RECIP_HI);
      ll2_in = (2*LO_W)'(mag1_ff[LO_W-1:0]) * (2*LO_W)'(RECIP_LO);
   end

   // Stage 3: quotient estimate, low by at most one
   logic [2*MW-1:0] full;
   logic [MW-1:0]   qest3_in, qest3_ff, mag3_ff;
   logic            neg3_ff;

   always_comb begin
      full = ((2*MW)'(hh2_ff) << (2*LO_W))
           + (((2*MW)'(hl2_ff) + (2*MW)'(lh2_ff)) << LO_W)
           + (2*MW)'(ll2_ff);
      qest3_in = full[2*MW-1:MW];
   end

   // Stage 4: correction, sign and saturation
   logic [MW-1:0]                 qd, rem, qfix;
   logic signed [COORD_WIDTH-1:0] val4_in, val4_ff;

   always_comb begin
      qd   = qest3_ff * MW'(DEN);
      rem  = mag3_ff - qd;
      qfix = qest3_ff + MW'(rem >= MW'(DEN));
      if (!neg3_ff) begin
         val4_in = (qfix > SAT_POS) ? SAT_POS[COORD_WIDTH-1:0] : qfix[COORD_WIDTH-1:0];
      end else begin
         val4_in = (qfix > SAT_NEG) ? SAT_NEG[COORD_WIDTH-1:0] : -qfix[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         mag1_ff <= mag1_in;
         neg1_ff <= num[NW-1];
      end
      if (en.s2) begin
         hh2_ff  <= hh2_in;
         hl2_ff  <= hl2_in;
         lh2_ff  <= lh2_in;
         ll2_ff  <= ll2_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
      if (en.s3) begin
         qest3_ff <= qest3_in;
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
      end
      if (en.s4) begin
         val4_ff <= val4_in;
      end
   end

   assign value = val4_ff;

endmodule

@@ src/qbs_pipe.sv @@
module qbs_pipe (
   input  logic              clock,
   input  logic              reset,
   input  qbs_pkg::step_type step,
   input  logic              step_valid,
   output logic              step_ready,
   qbs_rsp_if.source         rsp
);
   import qbs_pkg::*;

   localparam int STAGES = 4;

   logic [STAGES-1:0] v_ff, v_in, last_ff, last_in, rdy;
   pipe_en_type       en;
   logic signed [COORD_WIDTH-1:0] val_x, val_y;

   // A stage moves when it is empty or the next one moves
   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || rsp.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      en.s1 = rdy[0];
      en.s2 = rdy[1];
      en.s3 = rdy[2];
      en.s4 = rdy[3];
      step_ready = rdy[0];

      v_in[0]    = rdy[0] ? step_valid : v_ff[0];
      last_in[0] = rdy[0] ? step.last : last_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         v_in[i]    = rdy[i] ? v_ff[i-1] : v_ff[i];
         last_in[i] = rdy[i] ? last_ff[i-1] : last_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   qbs_lane u_lane_x (
      .clock (clock),
      .en    (en),
      .trip  (step.tx),
      .k     (step.k),
      .value (val_x)
   );

   qbs_lane u_lane_y (
      .clock (clock),
      .en    (en),
      .trip  (step.ty),
      .k     (step.k),
      .value (val_y)
   );

   assign rsp.valid    = v_ff[STAGES-1];
   assign rsp.smooth_x = val_x;
   assign rsp.smooth_y = val_y;
   assign rsp.path_end = last_ff[STAGES-1];

`ifndef NO_ASSERTIONS
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_ready |=> v_ff[0])
      else $error("taken item missing from first stage");
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && !rdy[1] |=> v_ff[0])
      else $error("first stage dropped a stalled item");
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && !rdy[3] |=> v_ff[2])
      else $error("third stage dropped a stalled item");
`endif

endmodule

@@ src/quadratic_bspline_path_smoother_unit.sv @@
// Channel   Dir  Payload                              Handshake
// req_chan  in   point_x, point_y, final_point        valid/ready
// rsp_chan  out  smooth_x, smooth_y, path_end         valid/ready
//
// One result leaves per cycle while rsp_chan is ready. An item gives as many
// results as its job holds: 3 for an interior point, 7 for the final point of
// a longer path, 1 or 2 for short paths, none for the first point of a longer path.
// The job sequencer sets these counts; results pass through a four stage
// evaluation pipe ending in the output register. Synchronous reset clears
// the point count, job state and pipe valids. A stalled rsp_chan fills the
// pipe, then holds req_chan not ready.
module quadratic_bspline_path_smoother_unit (
   input  logic      clock,
   input  logic      reset,
   qbs_req_if.sink   req_chan,
   qbs_rsp_if.source rsp_chan
);
   import qbs_pkg::*;

   step_type step;
   logic     step_valid;
   logic     step_ready;

   qbs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .step       (step),
      .step_valid (step_valid),
      .step_ready (step_ready)
   );

   qbs_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .step_valid (step_valid),
      .step_ready (step_ready),
      .rsp        (rsp_chan)
   );

endmodule

@@ tb/qbs_path_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the path smoother, predicts the smoothed path from
// every accepted point and compares each accepted result against the oldest
// prediction.
module qbs_path_checker (
   input  logic clock,
   input  logic reset,
   qbs_req_if   req_mon,
   qbs_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_points
);
   import qbs_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      path_end;
   } smooth_point_type;

   localparam longint COORD_HI = (longint'(1) << (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_LO = -COORD_HI - 1;

   smooth_point_type expected_path[$];

   // Path history of the predictor
   coord_type prev2_x, prev2_y;
   coord_type prev1_x, prev1_y;
   int        path_len;

   // One sample of a segment: exact numerator, rounded half away from zero,
   // then clamped to the coordinate range
   function automatic coord_type spline_coord(longint q0, longint q1, longint q2, longint k);
      longint s, num, den, half, r;
      s    = SEGMENTS;
      num  = s * s * (q0 + q1) + 2 * s * k * (q1 - q0) + k * k * (q0 - 2 * q1 + q2);
      den  = 2 * s * s;
      half = s * s;
      if (num >= 0) r = (num + half) / den;
      else          r = -((-num + half) / den);
      if (r > COORD_HI) r = COORD_HI;
      if (r < COORD_LO) r = COORD_LO;
      return coord_type'(r);
   endfunction

   task automatic push_point(coord_type x, coord_type y, logic path_end);
      smooth_point_type p;
      p.x        = x;
      p.y        = y;
      p.path_end = path_end;
      expected_path.insert(expected_path.size(), p);
   endtask

   task automatic push_segment(longint x0, longint y0, longint x1, longint y1,
                               longint x2, longint y2);
      for (int k = 0; k < SEGMENTS; k++) begin
         push_point(spline_coord(x0, x1, x2, k), spline_coord(y0, y1, y2, k), 1'b0);
      end
   endtask

   task automatic clear_history();
      prev2_x  = '0;
      prev2_y  = '0;
      prev1_x  = '0;
      prev1_y  = '0;
      path_len = 0;
   endtask

   // Expected results for one accepted point
   task automatic predict_point(coord_type x, coord_type y, logic last);
      longint px, py, ax, ay, bx, by;
      px = x;
      py = y;
      ax = prev2_x;
      ay = prev2_y;
      bx = prev1_x;
      by = prev1_y;
      if (path_len == 0) begin
         if (last) begin
            push_point(x, y, 1'b1);
            clear_history();
         end else begin
            prev1_x  = x;
            prev1_y  = y;
            path_len = 1;
         end
      end else if (path_len == 1 && last) begin
         // two point path passes through
         push_point(prev1_x, prev1_y, 1'b0);
         push_point(x, y, 1'b1);
         clear_history();
      end else begin
         if (path_len == 1) begin
            // front of the path: reflected lead-in point
            push_segment(2 * bx - px, 2 * by - py, bx, by, px, py);
         end else begin
            push_segment(ax, ay, bx, by, px, py);
         end
         if (last && path_len == 2) begin
            // back of the path: reflected tail point, then the end point
            push_segment(bx, by, px, py, 2 * px - bx, 2 * py - by);
            push_point(x, y, 1'b1);
            clear_history();
         end else begin
            prev2_x  = prev1_x;
            prev2_y  = prev1_y;
            prev1_x  = x;
            prev1_y  = y;
            path_len = 2;
         end
      end
   endtask

   // Predict on accepted points, compare on accepted results
   always @(posedge clock) begin
      smooth_point_type exp_pt;
      int               errs;
      if (reset) begin
         expected_path.delete();
         clear_history();
         mismatch_count <= 0;
         pending_points <= 0;
      end else begin
         errs = 0;
         if (req_mon.valid && req_mon.ready) begin
            predict_point(req_mon.point_x, req_mon.point_y, req_mon.final_point);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_path.size() == 0) begin
               $error("unexpected result: smooth_x %0d smooth_y %0d path_end %0b",
                      rsp_mon.smooth_x, rsp_mon.smooth_y, rsp_mon.path_end);
               errs++;
            end else begin
               exp_pt = expected_path.pop_front();
               if (rsp_mon.smooth_x !== exp_pt.x) begin
                  $error("smooth_x mismatch: expected %0d, actual %0d",
                         exp_pt.x, rsp_mon.smooth_x);
                  errs++;
               end
               if (rsp_mon.smooth_y !== exp_pt.y) begin
                  $error("smooth_y mismatch: expected %0d, actual %0d",
                         exp_pt.y, rsp_mon.smooth_y);
                  errs++;
               end
               if (rsp_mon.path_end !== exp_pt.path_end) begin
                  $error("path_end mismatch: expected %0b, actual %0b",
                         exp_pt.path_end, rsp_mon.path_end);
                  errs++;
               end
            end
         end
         mismatch_count <= mismatch_count + errs;
         pending_points <= expected_path.size();
      end
   end

endmodule

@@ tb/quadratic_bspline_path_smoother_unit_test.sv @@
`timescale 1ns / 100ps

module quadratic_bspline_path_smoother_unit_test;
   import qbs_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type COORD_MAX    = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam coord_type COORD_MIN    = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
   localparam int        ITEM_TARGET  = 150;
   localparam int        HOLD_CYCLES  = 80;
   localparam int        CYCLE_LIMIT  = 200000;
   localparam int        DRAIN_CYCLES = 12;

   // Kinds of coordinate content in a random path
   typedef enum int {COORD_WIDE, COORD_NEAR, COORD_CORNER} coord_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   send_idle_pct = 25;
   int   recv_idle_pct = 63;
   int   items_sent    = 0;
   int   cycle_count   = 0;
   logic hold_request  = 1'b0;
   logic hold_done     = 1'b0;
   int   mismatch_count;
   int   pending_points;

   qbs_req_if req_chan ();
   qbs_rsp_if rsp_chan ();

   quadratic_bspline_path_smoother_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   qbs_path_checker path_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_points (pending_points)
   );

   always #2 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one point and wait until it is taken
   task automatic send_point(coord_type x, coord_type y, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.point_x     <= x;
      req_chan.point_y     <= y;
      req_chan.final_point <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      // idle pattern swaps after the first third of the run and drops to none after the second
      if (items_sent == ITEM_TARGET / 3) begin
         send_idle_pct = 63;
         recv_idle_pct = 25;
      end else if (items_sent == 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if (items_sent == 2 * ITEM_TARGET / 3 + 10) hold_request = 1'b1;
   endtask

   function automatic coord_type pick_coord(coord_mode_type mode, coord_type base);
      case (mode)
         COORD_WIDE: begin
            return coord_type'($urandom);
         end
         COORD_NEAR: begin
            return base + coord_type'($urandom_range(0, 1 << 20)) - coord_type'(1 << 19);
         end
         default: begin
            case ($urandom_range(3))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off while points keep coming
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Stimulus
   initial begin
      coord_mode_type mode;
      coord_type      bx, by;
      int             len, pick;
      req_chan.valid       = 1'b0;
      req_chan.point_x     = '0;
      req_chan.point_y     = '0;
      req_chan.final_point = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single point paths
      send_point(COORD_MAX, COORD_MIN, 1'b1);
      send_point('0, '1, 1'b1);
      // two point path
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 1'b1);
      // three points at the corners: both reflections saturate
      send_point(COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, 1'b1);
      // ordinary four point path with mixed signs
      send_point(32'sd0, 32'sd0, 1'b0);
      send_point(32'sd100, -32'sd100, 1'b0);
      send_point(-32'sd50, 32'sd7, 1'b0);
      send_point(32'sd123456, -32'sd654321, 1'b1);
      // five points swinging between extremes
      send_point(COORD_MIN, '0, 1'b0);
      send_point(COORD_MIN, '0, 1'b0);
      send_point(COORD_MAX, '1, 1'b0);
      send_point('0, COORD_MAX, 1'b0);
      send_point(COORD_MIN, COORD_MIN, 1'b1);

      // random paths, always closed by a final point
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 15)      len = 1;
         else if (pick < 30) len = 2;
         else if (pick < 95) len = $urandom_range(3, 10);
         else                len = 25;
         pick = $urandom_range(99);
         if (pick < 30)      mode = COORD_WIDE;
         else if (pick < 80) mode = COORD_NEAR;
         else                mode = COORD_CORNER;
         bx = coord_type'($urandom);
         by = coord_type'($urandom);
         for (int i = 0; i < len; i++) begin
            bx = pick_coord(mode, bx);
            by = pick_coord(mode, by);
            send_point(bx, by, i == len - 1);
         end
      end
      req_chan.valid <= 1'b0;

      // let the checker count the last point, drain, then allow for stray results
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_points == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
